/* src/ile_pkg.sv */
// Package for the indexed list engine: sizes, command codes and sequencer states.
// Used by the channel interfaces, the top level and the checker.
package ile_pkg;

  // List capacity and the widths that follow from it.
  localparam int LIST_DEPTH = 64;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int CMD_W      = 4;
  localparam int DATA_W     = 32;

  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] word_t;

  // Command codes carried in the cmd field.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 4'd0,
    CMD_INSERT   = 4'd1,
    CMD_REMOVE   = 4'd2,
    CMD_GET      = 4'd3,
    CMD_SET      = 4'd4,
    CMD_SWAP     = 4'd5,
    CMD_CONTAINS = 4'd6,
    CMD_INDEX_OF = 4'd7,
    CMD_CLEAR    = 4'd8
  } cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_WR,
    ST_REM_RD,
    ST_REM_WR,
    ST_GET,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SWAP_C,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FINISH
  } state_t;

endpackage

/* src/ile_ifs.sv */
// Valid/ready channel interfaces for the indexed list engine: command and reply.
// Depends on ile_pkg for field widths.
interface ile_req_if;
  import ile_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [6:0]              position;
  logic [5:0]              other_position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, position, other_position, value, input ready);
  modport sink   (input valid, cmd, position, other_position, value, output ready);
endinterface

interface ile_rsp_if;
  import ile_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic signed [6:0]        found_position;
  logic [6:0]               element_total;
  logic                     is_empty;

  modport source (output valid, ok, read_value, found_position, element_total, is_empty,
                  input ready);
  modport sink   (input valid, ok, read_value, found_position, element_total, is_empty,
                  output ready);
endinterface

/* src/indexed_list_engine.sv */
// Indexed list engine: fixed-capacity ordered list of signed words in a local memory.
// Depends on ile_pkg and the channel interfaces in ile_ifs.sv.
//
//   channel | direction | fields
//   req     | in        | cmd, position, other_position, value
//   rsp     | out       | ok, read_value, found_position, element_total, is_empty
//
// One command at a time goes through a sequencer around a memory with one write port and
// a registered read port. Insert and remove shift entries with a read and a write per
// entry moved, and a search reads and compares each entry visited. The next command is
// accepted once the sequencer is idle, even while the previous reply waits; a stalled
// reply holds the sequencer in its last state. Reset clears the sequencer state, the
// count and the reply valid, not the memory.
module indexed_list_engine (
  input  logic          clk,
  input  logic          rst,
  ile_req_if.sink       req,
  ile_rsp_if.source     rsp
);
  import ile_pkg::*;

  // Entry storage.
  word_t mem [LIST_DEPTH];
  word_t rd_data;

  // Sequencer and working registers.
  state_t state, state_next;
  count_t element_count;
  count_t idx, idx_next;
  word_t  tmp, tmp_next;
  logic [CMD_W-1:0] cmd_q;
  count_t pos_q;
  addr_t  pos2_q;
  word_t  val_q;

  logic   res_ok, res_ok_next;
  word_t  res_rd, res_rd_next;
  logic signed [6:0] res_fp, res_fp_next;
  count_t res_count, res_count_next;

  // Reply register.
  logic              out_valid;
  logic              out_ok;
  word_t             out_rd;
  logic signed [6:0] out_fp;
  count_t            out_total;

  // Memory port controls.
  logic   mem_we;
  addr_t  mem_waddr;
  word_t  mem_wdata;
  addr_t  mem_raddr;

  logic req_fire;
  logic out_free;
  logic in_full;
  logic pos_ok;
  logic pos2_ok;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign in_full = (element_count == CNT_W'(LIST_DEPTH));
  assign pos_ok  = (pos_q < element_count);
  assign pos2_ok = ({1'b0, pos2_q} < element_count);

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Next state, memory controls and working register updates.
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    tmp_next       = tmp;
    res_ok_next    = res_ok;
    res_rd_next    = res_rd;
    res_fp_next    = res_fp;
    res_count_next = res_count;
    mem_we         = 1'b0;
    mem_waddr      = pos_q[ADDR_W-1:0];
    mem_wdata      = val_q;
    mem_raddr      = idx[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next     = ST_DECODE;
          res_ok_next    = 1'b0;
          res_rd_next    = '0;
          res_fp_next    = '0;
          res_count_next = element_count;
          idx_next       = '0;
        end
      end

      ST_DECODE: begin
        state_next = ST_FINISH;
        case (cmd_q)
          CMD_APPEND: begin
            if (!in_full) begin
              mem_we         = 1'b1;
              mem_waddr      = element_count[ADDR_W-1:0];
              res_ok_next    = 1'b1;
              res_count_next = element_count + 1'b1;
            end
          end
          CMD_INSERT: begin
            if (pos_q <= element_count && !in_full) begin
              idx_next       = element_count;
              res_ok_next    = 1'b1;
              res_count_next = element_count + 1'b1;
              state_next     = ST_INS_RD;
            end
          end
          CMD_REMOVE: begin
            if (pos_ok) begin
              idx_next       = pos_q;
              res_ok_next    = 1'b1;
              res_count_next = element_count - 1'b1;
              state_next     = ST_REM_RD;
            end
          end
          CMD_GET: begin
            if (pos_ok) begin
              mem_raddr  = pos_q[ADDR_W-1:0];
              state_next = ST_GET;
            end else begin
              res_rd_next = '1;
            end
          end
          CMD_SET: begin
            if (pos_ok) begin
              mem_we      = 1'b1;
              res_ok_next = 1'b1;
            end
          end
          CMD_SWAP: begin
            if (pos_ok && pos2_ok) begin
              mem_raddr  = pos_q[ADDR_W-1:0];
              state_next = ST_SWAP_A;
            end
          end
          CMD_CONTAINS, CMD_INDEX_OF: begin
            idx_next   = '0;
            state_next = ST_SRCH_RD;
          end
          CMD_CLEAR: begin
            res_ok_next    = 1'b1;
            res_count_next = '0;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end

      // Insert: move entries up one at a time from the top, then place the new value.
      ST_INS_RD: begin
        if (idx == pos_q) begin
          mem_we     = 1'b1;
          state_next = ST_FINISH;
        end else begin
          mem_raddr  = ADDR_W'(idx - 1'b1);
          state_next = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[ADDR_W-1:0];
        mem_wdata  = rd_data;
        idx_next   = idx - 1'b1;
        state_next = ST_INS_RD;
      end

      // Remove: move entries down one at a time from the removed position.
      ST_REM_RD: begin
        if (idx + 1'b1 >= element_count) begin
          state_next = ST_FINISH;
        end else begin
          mem_raddr  = ADDR_W'(idx + 1'b1);
          state_next = ST_REM_WR;
        end
      end

      ST_REM_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[ADDR_W-1:0];
        mem_wdata  = rd_data;
        idx_next   = idx + 1'b1;
        state_next = ST_REM_RD;
      end

      ST_GET: begin
        res_rd_next = rd_data;
        res_ok_next = 1'b1;
        state_next  = ST_FINISH;
      end

      // Swap: hold the first entry, write the second over it, then the first back.
      ST_SWAP_A: begin
        tmp_next   = rd_data;
        mem_raddr  = pos2_q;
        state_next = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        mem_we     = 1'b1;
        mem_wdata  = rd_data;
        state_next = ST_SWAP_C;
      end

      ST_SWAP_C: begin
        mem_we      = 1'b1;
        mem_waddr   = pos2_q;
        mem_wdata   = tmp;
        res_ok_next = 1'b1;
        state_next  = ST_FINISH;
      end

      // Search: one entry per read and compare, from the bottom up.
      ST_SRCH_RD: begin
        if (idx >= element_count) begin
          if (cmd_q == CMD_INDEX_OF) begin
            res_fp_next = '1;
          end
          state_next = ST_FINISH;
        end else begin
          mem_raddr  = idx[ADDR_W-1:0];
          state_next = ST_SRCH_CMP;
        end
      end

      ST_SRCH_CMP: begin
        if (rd_data == val_q) begin
          res_ok_next = 1'b1;
          if (cmd_q == CMD_INDEX_OF) begin
            res_fp_next = idx;
          end
          state_next = ST_FINISH;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SRCH_RD;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, count and reply valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        element_count <= res_count;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and reply payload registers.
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    tmp       <= tmp_next;
    res_ok    <= res_ok_next;
    res_rd    <= res_rd_next;
    res_fp    <= res_fp_next;
    res_count <= res_count_next;
    if (req_fire) begin
      cmd_q  <= req.cmd;
      pos_q  <= req.position;
      pos2_q <= req.other_position;
      val_q  <= req.value;
    end
    if (state == ST_FINISH && out_free) begin
      out_ok    <= res_ok;
      out_rd    <= res_rd;
      out_fp    <= res_fp;
      out_total <= res_count;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_ok;
  assign rsp.read_value     = out_rd;
  assign rsp.found_position = out_fp;
  assign rsp.element_total  = out_total;
  assign rsp.is_empty       = (out_total == '0);

endmodule

/* src/ile_checker.sv */
// Port-level checks for the indexed list engine, attached to the top level by bind.
// Depends on ile_pkg for the list capacity.
module ile_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_ok,
  input logic [31:0] rsp_read_value,
  input logic [6:0]  rsp_found_position,
  input logic [6:0]  rsp_element_total,
  input logic        rsp_is_empty
);
  import ile_pkg::*;

  // The count in a reply never exceeds the capacity.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_element_total <= CNT_W'(LIST_DEPTH))
    else $error("element_total above list capacity");

  // The empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_is_empty == (rsp_element_total == 7'd0))
    else $error("is_empty disagrees with element_total");

  // A failed command reports a found position of zero or the miss code.
  a_found_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (rsp_found_position == 7'd0 || rsp_found_position == 7'h7F))
    else $error("found_position set on a failed command");

  // Only one command is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("command accepted while another is in work");

  // A stalled reply holds its valid, read value, count and ok flag.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_read_value)
      && $stable(rsp_element_total) && $stable(rsp_ok))
    else $error("stalled reply changed");

endmodule

bind indexed_list_engine ile_port_checks u_ile_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_ok             (rsp.ok),
  .rsp_read_value     (rsp.read_value),
  .rsp_found_position (rsp.found_position),
  .rsp_element_total  (rsp.element_total),
  .rsp_is_empty       (rsp.is_empty)
);
